/* src/assert_macros.svh */
// Concurrent assertion helpers for the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define OLE_ASSERT(name, clk, rstn, prop) \
  name: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
    else $error("assertion failed");
`define OLE_ASSERT_NEXT(name, clk, rstn, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define OLE_ASSERT(name, clk, rstn, prop)
`define OLE_ASSERT_NEXT(name, clk, rstn, ante, cons)
`endif
`endif

/* src/ole_pkg.sv */
package ole_pkg;

  localparam int OpW  = 3;
  localparam int ValW = 32;
  localparam int PosW = 6;
  localparam int StW  = 3;
  localparam int LenW = 7;

  localparam logic [OpW-1:0] OP_INS_FRONT = 3'd0;
  localparam logic [OpW-1:0] OP_INS_BACK  = 3'd1;
  localparam logic [OpW-1:0] OP_INS_AFTER = 3'd2;
  localparam logic [OpW-1:0] OP_DEL_FRONT = 3'd3;
  localparam logic [OpW-1:0] OP_DEL_BACK  = 3'd4;
  localparam logic [OpW-1:0] OP_DEL_AT    = 3'd5;
  localparam logic [OpW-1:0] OP_SEARCH    = 3'd6;
  localparam logic [OpW-1:0] OP_DUMP      = 3'd7;

  localparam logic [StW-1:0] ST_OK        = 3'd0;
  localparam logic [StW-1:0] ST_EMPTY     = 3'd1;
  localparam logic [StW-1:0] ST_FULL      = 3'd2;
  localparam logic [StW-1:0] ST_RANGE     = 3'd3;
  localparam logic [StW-1:0] ST_NOT_FOUND = 3'd4;

  typedef struct packed {
    logic           capture;
    logic           ptr_load;
    logic           ptr_inc;
    logic           ptr_dec;
    logic           rd_en;
    logic           rd_move;
    logic           wr_move;
    logic           wr_new;
    logic           cnt_inc;
    logic           cnt_dec;
    logic           emit;
    logic           emit_dump;
    logic           emit_idx;
    logic [StW-1:0] emit_st;
  } cmd_t;

  typedef struct packed {
    logic [OpW-1:0] op;
    logic           empty;
    logic           full;
    logic           pos_bad;
    logic           more;
    logic           hit;
    logic           last_elem;
    logic           out_free;
  } sts_t;

endpackage

/* src/ole_ram.sv */
module ole_ram #(
  parameter int Width = 32,
  parameter int Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* src/ole_ctrl.sv */
module ole_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  input  ole_pkg::sts_t sts_i,
  output ole_pkg::cmd_t cmd_o
);

  localparam logic [3:0] S_IDLE    = 4'd0;
  localparam logic [3:0] S_CHECK   = 4'd1;
  localparam logic [3:0] S_MOVE_RD = 4'd2;
  localparam logic [3:0] S_MOVE_WR = 4'd3;
  localparam logic [3:0] S_FINISH  = 4'd4;
  localparam logic [3:0] S_SRC_RD  = 4'd5;
  localparam logic [3:0] S_SRC_CHK = 4'd6;
  localparam logic [3:0] S_DMP_RD  = 4'd7;
  localparam logic [3:0] S_DMP_OUT = 4'd8;
  localparam logic [3:0] S_EMIT    = 4'd9;

  logic [3:0]              state_q, state_d;
  logic [ole_pkg::StW-1:0] st_q, st_d;
  logic                    idx_q, idx_d;
  logic                    is_ins;

  assign is_ins = (sts_i.op == ole_pkg::OP_INS_FRONT) ||
                  (sts_i.op == ole_pkg::OP_INS_BACK) ||
                  (sts_i.op == ole_pkg::OP_INS_AFTER);
  assign in_stall_o = (state_q != S_IDLE);

  always_comb begin
    state_d = state_q;
    st_d    = st_q;
    idx_d   = idx_q;
    cmd_o   = '0;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d       = S_CHECK;
        end
      end
      S_CHECK: begin
        st_d  = ole_pkg::ST_OK;
        idx_d = 1'b0;
        case (sts_i.op)
          ole_pkg::OP_INS_FRONT, ole_pkg::OP_INS_BACK: begin
            if (sts_i.full) begin
              st_d = ole_pkg::ST_FULL; state_d = S_EMIT;
            end else begin
              cmd_o.ptr_load = 1'b1; state_d = S_MOVE_RD;
            end
          end
          ole_pkg::OP_INS_AFTER: begin
            if (sts_i.empty) begin
              st_d = ole_pkg::ST_EMPTY; state_d = S_EMIT;
            end else if (sts_i.full) begin
              st_d = ole_pkg::ST_FULL; state_d = S_EMIT;
            end else if (sts_i.pos_bad) begin
              st_d = ole_pkg::ST_RANGE; state_d = S_EMIT;
            end else begin
              cmd_o.ptr_load = 1'b1; state_d = S_MOVE_RD;
            end
          end
          ole_pkg::OP_DEL_FRONT, ole_pkg::OP_DEL_BACK: begin
            if (sts_i.empty) begin
              st_d = ole_pkg::ST_EMPTY; state_d = S_EMIT;
            end else begin
              cmd_o.ptr_load = 1'b1; state_d = S_MOVE_RD;
            end
          end
          ole_pkg::OP_DEL_AT: begin
            if (sts_i.empty) begin
              st_d = ole_pkg::ST_EMPTY; state_d = S_EMIT;
            end else if (sts_i.pos_bad) begin
              st_d = ole_pkg::ST_RANGE; state_d = S_EMIT;
            end else begin
              cmd_o.ptr_load = 1'b1; state_d = S_MOVE_RD;
            end
          end
          ole_pkg::OP_SEARCH: begin
            if (sts_i.empty) begin
              st_d = ole_pkg::ST_EMPTY; state_d = S_EMIT;
            end else begin
              cmd_o.ptr_load = 1'b1; state_d = S_SRC_RD;
            end
          end
          default: begin
            if (sts_i.empty) begin
              st_d = ole_pkg::ST_EMPTY; state_d = S_EMIT;
            end else begin
              cmd_o.ptr_load = 1'b1; state_d = S_DMP_RD;
            end
          end
        endcase
      end
      S_MOVE_RD: begin
        if (sts_i.more) begin
          cmd_o.rd_en   = 1'b1;
          cmd_o.rd_move = 1'b1;
          state_d       = S_MOVE_WR;
        end else begin
          state_d = S_FINISH;
        end
      end
      S_MOVE_WR: begin
        // Inserts walk toward the front, deletes toward the back.
        cmd_o.wr_move = 1'b1;
        cmd_o.ptr_dec = is_ins;
        cmd_o.ptr_inc = !is_ins;
        state_d       = S_MOVE_RD;
      end
      S_FINISH: begin
        cmd_o.wr_new  = is_ins;
        cmd_o.cnt_inc = is_ins;
        cmd_o.cnt_dec = !is_ins;
        state_d       = S_EMIT;
      end
      S_SRC_RD: begin
        cmd_o.rd_en = 1'b1;
        state_d     = S_SRC_CHK;
      end
      S_SRC_CHK: begin
        if (sts_i.hit) begin
          idx_d = 1'b1; state_d = S_EMIT;
        end else if (sts_i.last_elem) begin
          st_d = ole_pkg::ST_NOT_FOUND; state_d = S_EMIT;
        end else begin
          cmd_o.ptr_inc = 1'b1; state_d = S_SRC_RD;
        end
      end
      S_DMP_RD: begin
        cmd_o.rd_en = 1'b1;
        state_d     = S_DMP_OUT;
      end
      S_DMP_OUT: begin
        if (sts_i.out_free) begin
          cmd_o.emit      = 1'b1;
          cmd_o.emit_dump = 1'b1;
          cmd_o.emit_idx  = 1'b1;
          cmd_o.emit_st   = ole_pkg::ST_OK;
          if (sts_i.last_elem) begin
            state_d = S_IDLE;
          end else begin
            cmd_o.ptr_inc = 1'b1;
            state_d       = S_DMP_RD;
          end
        end
      end
      S_EMIT: begin
        if (sts_i.out_free) begin
          cmd_o.emit     = 1'b1;
          cmd_o.emit_idx = idx_q;
          cmd_o.emit_st  = st_q;
          state_d        = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      st_q    <= ole_pkg::ST_OK;
      idx_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      st_q    <= st_d;
      idx_q   <= idx_d;
    end
  end

endmodule

/* src/ole_dp.sv */
`include "assert_macros.svh"
module ole_dp #(
  parameter int CAPACITY = 16
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  ole_pkg::cmd_t                   cmd_i,
  output ole_pkg::sts_t                   sts_o,
  input  logic [ole_pkg::OpW-1:0]         opcode_i,
  input  logic signed [ole_pkg::ValW-1:0] value_i,
  input  logic [ole_pkg::PosW-1:0]        position_i,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output logic [ole_pkg::StW-1:0]         status_o,
  output logic signed [ole_pkg::ValW-1:0] data_o,
  output logic [ole_pkg::PosW-1:0]        index_o,
  output logic [ole_pkg::LenW-1:0]        length_o,
  output logic                            last_o
);

  localparam int CW = $clog2(CAPACITY + 1);
  localparam int AW = $clog2(CAPACITY);

  logic [ole_pkg::OpW-1:0]  op_q;
  logic [ole_pkg::ValW-1:0] val_q;
  logic [ole_pkg::PosW-1:0] pos_q;
  logic [CW-1:0]            count_q, ptr_q, at, rd_ptr;
  logic [CW:0]              ptr_nx;
  logic [ole_pkg::LenW-1:0] pos_ext, count_ext, ptr_ext;
  logic                     is_ins, out_free;
  logic [ole_pkg::ValW-1:0] rd_data;
  logic                     out_valid_q, out_last_q;
  logic [ole_pkg::StW-1:0]  out_st_q;
  logic [ole_pkg::ValW-1:0] out_data_q;
  logic [ole_pkg::PosW-1:0] out_idx_q;
  logic [ole_pkg::LenW-1:0] out_len_q;

  assign is_ins = (op_q == ole_pkg::OP_INS_FRONT) || (op_q == ole_pkg::OP_INS_BACK) ||
                  (op_q == ole_pkg::OP_INS_AFTER);
  assign pos_ext   = {1'b0, pos_q};
  assign count_ext = ole_pkg::LenW'(count_q);
  assign ptr_ext   = ole_pkg::LenW'(ptr_q);
  assign ptr_nx    = {1'b0, ptr_q} + {{CW{1'b0}}, 1'b1};
  assign out_free  = !out_valid_q || !out_stall_i;

  // Insert sites for inserts, removal sites for deletes.
  always_comb begin
    case (op_q)
      ole_pkg::OP_INS_BACK:  at = count_q;
      ole_pkg::OP_INS_AFTER: at = CW'(pos_ext + 7'd1);
      ole_pkg::OP_DEL_BACK:  at = count_q - {{(CW-1){1'b0}}, 1'b1};
      ole_pkg::OP_DEL_AT:    at = CW'(pos_ext);
      default:               at = '0;
    endcase
  end

  assign rd_ptr = !cmd_i.rd_move ? ptr_q :
                  is_ins ? (ptr_q - {{(CW-1){1'b0}}, 1'b1}) : ptr_nx[CW-1:0];

  ole_ram #(.Width(ole_pkg::ValW), .Depth(CAPACITY)) u_ram (
    .clk_i   (clk_i),
    .we_i    (cmd_i.wr_move || cmd_i.wr_new),
    .waddr_i (cmd_i.wr_new ? at[AW-1:0] : ptr_q[AW-1:0]),
    .wdata_i (cmd_i.wr_new ? val_q : rd_data),
    .re_i    (cmd_i.rd_en),
    .raddr_i (rd_ptr[AW-1:0]),
    .rdata_o (rd_data)
  );

  assign sts_o.op        = op_q;
  assign sts_o.empty     = (count_q == '0);
  assign sts_o.full      = (count_q == CW'(CAPACITY));
  assign sts_o.pos_bad   = (pos_ext >= count_ext);
  assign sts_o.more      = is_ins ? (ptr_q > at) : (ptr_nx < {1'b0, count_q});
  assign sts_o.hit       = (rd_data == val_q);
  assign sts_o.last_elem = (ptr_nx == {1'b0, count_q});
  assign sts_o.out_free  = out_free;

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      op_q  <= opcode_i;
      val_q <= value_i;
      pos_q <= position_i;
    end
    if (cmd_i.ptr_load) begin
      ptr_q <= is_ins ? count_q : at;
    end else if (cmd_i.ptr_inc) begin
      ptr_q <= ptr_nx[CW-1:0];
    end else if (cmd_i.ptr_dec) begin
      ptr_q <= ptr_q - {{(CW-1){1'b0}}, 1'b1};
    end
    if (cmd_i.emit) begin
      out_st_q   <= cmd_i.emit_st;
      out_data_q <= cmd_i.emit_dump ? rd_data : '0;
      out_idx_q  <= cmd_i.emit_idx ? ptr_ext[ole_pkg::PosW-1:0] : '0;
      out_len_q  <= count_ext;
      out_last_q <= cmd_i.emit_dump ? sts_o.last_elem : 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.cnt_inc) begin
        count_q <= count_q + {{(CW-1){1'b0}}, 1'b1};
      end else if (cmd_i.cnt_dec) begin
        count_q <= count_q - {{(CW-1){1'b0}}, 1'b1};
      end
      if (cmd_i.emit) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign status_o    = out_st_q;
  assign data_o      = out_data_q;
  assign index_o     = out_idx_q;
  assign length_o    = out_len_q;
  assign last_o      = out_last_q;

  `OLE_ASSERT(a_count_bound, clk_i, rst_ni, count_q <= CW'(CAPACITY))
  `OLE_ASSERT(a_new_not_full, clk_i, rst_ni, !cmd_i.wr_new || (count_q < CW'(CAPACITY)))
  `OLE_ASSERT_NEXT(a_count_inc, clk_i, rst_ni, cmd_i.cnt_inc,
                   count_q == $past(count_q) + {{(CW-1){1'b0}}, 1'b1})
  `OLE_ASSERT(a_emit_free, clk_i, rst_ni, !cmd_i.emit || out_free)

endmodule

/* src/ordered_list_engine.sv */
// Channel | Valid       | Stall       | Payload
// input   | in_valid_i  | in_stall_o  | opcode_i, value_i, position_i
// output  | out_valid_o | out_stall_i | status_o, data_o, index_o, length_o, last_o
//
// A word is taken only while the engine is idle; each command then runs to completion.
// Inserts and deletes move stored elements one at a time through the single RAM port
// pair, reading each in S_MOVE_RD and writing it in S_MOVE_WR; search reads and then
// checks each element visited; dump reads and emits each one, waiting out any stall.
// Reset clears the element count and the output valid flag; the RAM is not cleared.
// A result waiting in the output register does not block the next input word.
module ordered_list_engine #(
  parameter int CAPACITY = 16
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  logic [ole_pkg::OpW-1:0]         opcode_i,
  input  logic signed [ole_pkg::ValW-1:0] value_i,
  input  logic [ole_pkg::PosW-1:0]        position_i,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output logic [ole_pkg::StW-1:0]         status_o,
  output logic signed [ole_pkg::ValW-1:0] data_o,
  output logic [ole_pkg::PosW-1:0]        index_o,
  output logic [ole_pkg::LenW-1:0]        length_o,
  output logic                            last_o
);

  ole_pkg::cmd_t cmd;
  ole_pkg::sts_t sts;

  ole_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  ole_dp #(.CAPACITY(CAPACITY)) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .opcode_i    (opcode_i),
    .value_i     (value_i),
    .position_i  (position_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .status_o    (status_o),
    .data_o      (data_o),
    .index_o     (index_o),
    .length_o    (length_o),
    .last_o      (last_o)
  );

endmodule

/* tb/sv/ordered_list_engine_tb.sv */
`timescale 1ns / 100ps

module ordered_list_engine_tb;

  localparam int Capacity = 16;
  localparam int IdleLimit = 20000;
  localparam int OpW  = ole_pkg::OpW;
  localparam int ValW = ole_pkg::ValW;
  localparam int PosW = ole_pkg::PosW;
  localparam int StW  = ole_pkg::StW;
  localparam int LenW = ole_pkg::LenW;

  typedef struct packed {
    logic [StW-1:0]  status;
    logic [ValW-1:0] data;
    logic [PosW-1:0] index;
    logic [LenW-1:0] length;
    logic            last;
  } result_t;

  // Keeps a copy of the list and queues the results each command should produce.
  class list_scoreboard;
    logic [ValW-1:0] elems[$];
    result_t pending[$];
    int errors;

    function void push_result(logic [StW-1:0] st, logic [ValW-1:0] dat,
                              logic [PosW-1:0] idx, logic fin);
      result_t r;
      r.status = st;
      r.data = dat;
      r.index = idx;
      r.length = LenW'(elems.size());
      r.last = fin;
      pending.push_back(r);
    endfunction

    function void note_command(logic [OpW-1:0] op, logic [ValW-1:0] val,
                               logic [PosW-1:0] pos);
      logic [StW-1:0] st;
      logic [PosW-1:0] idx;
      int n;
      st = ole_pkg::ST_OK;
      idx = '0;
      n = elems.size();
      case (op)
        ole_pkg::OP_INS_FRONT, ole_pkg::OP_INS_BACK: begin
          if (n >= Capacity) st = ole_pkg::ST_FULL;
          else if (op == ole_pkg::OP_INS_FRONT) elems.push_front(val);
          else elems.push_back(val);
        end
        ole_pkg::OP_INS_AFTER: begin
          if (n == 0) st = ole_pkg::ST_EMPTY;
          else if (n >= Capacity) st = ole_pkg::ST_FULL;
          else if (pos >= n) st = ole_pkg::ST_RANGE;
          else elems.insert(pos + 1, val);
        end
        ole_pkg::OP_DEL_FRONT, ole_pkg::OP_DEL_BACK: begin
          if (n == 0) st = ole_pkg::ST_EMPTY;
          else if (op == ole_pkg::OP_DEL_FRONT) void'(elems.pop_front());
          else void'(elems.pop_back());
        end
        ole_pkg::OP_DEL_AT: begin
          if (n == 0) st = ole_pkg::ST_EMPTY;
          else if (pos >= n) st = ole_pkg::ST_RANGE;
          else elems.delete(pos);
        end
        ole_pkg::OP_SEARCH: begin
          if (n == 0) st = ole_pkg::ST_EMPTY;
          else begin
            st = ole_pkg::ST_NOT_FOUND;
            for (int i = 0; i < n; i++) begin
              if (elems[i] == val) begin
                st = ole_pkg::ST_OK;
                idx = PosW'(i);
                break;
              end
            end
          end
        end
        default: begin
          if (n == 0) push_result(ole_pkg::ST_EMPTY, '0, '0, 1'b1);
          for (int i = 0; i < n; i++)
            push_result(ole_pkg::ST_OK, elems[i], PosW'(i), i == n - 1);
          return;
        end
      endcase
      push_result(st, '0, idx, 1'b1);
    endfunction

    function void check_result(result_t got);
      result_t want;
      if (pending.size() == 0) begin
        $error("unexpected result word: status %0d data %0h", got.status, got.data);
        errors++;
        return;
      end
      want = pending.pop_front();
      if (got.status !== want.status) begin
        $error("status: expected %0d, got %0d", want.status, got.status);
        errors++;
      end
      if (got.data !== want.data) begin
        $error("data: expected %0h, got %0h", want.data, got.data);
        errors++;
      end
      if (got.index !== want.index) begin
        $error("index: expected %0d, got %0d", want.index, got.index);
        errors++;
      end
      if (got.length !== want.length) begin
        $error("length: expected %0d, got %0d", want.length, got.length);
        errors++;
      end
      if (got.last !== want.last) begin
        $error("last: expected %0d, got %0d", want.last, got.last);
        errors++;
      end
    endfunction
  endclass

  logic clk_i, rst_ni;
  logic in_valid_i, in_stall_o;
  logic [OpW-1:0] opcode_i;
  logic signed [ValW-1:0] value_i;
  logic [PosW-1:0] position_i;
  logic out_valid_o, out_stall_i;
  logic [StW-1:0] status_o;
  logic signed [ValW-1:0] data_o;
  logic [PosW-1:0] index_o;
  logic [LenW-1:0] length_o;
  logic last_o;

  list_scoreboard board;
  int send_idle_pct, recv_idle_pct;
  int idle_cycles;

  ordered_list_engine #(.CAPACITY(Capacity)) u_dut (.*);

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    board = new();
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    opcode_i = '0;
    value_i = '0;
    position_i = '0;
    out_stall_i = 1'b0;
    send_idle_pct = 0;
    recv_idle_pct = 0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  // Receiver side: random stall, checks every accepted result word.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i)
        board.check_result({status_o, data_o, index_o, length_o, last_o});
      out_stall_i <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  // Watchdog on cycles with no accepted word on either side.
  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i))
      idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IdleLimit) begin
      $display("Verification failed");
      $finish;
    end
  end

  // Valid stays high after the accepting edge; the next call or drain() replaces it
  // in the same time step, so each time step sees one assignment to it.
  task automatic send_word(logic [OpW-1:0] op, logic [ValW-1:0] val, logic [PosW-1:0] pos);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    opcode_i <= op;
    value_i <= val;
    position_i <= pos;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    board.note_command(op, val, pos);
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    while (board.pending.size() != 0) @(posedge clk_i);
  endtask

  function automatic logic [ValW-1:0] pick_value();
    // Reuse stored values often so that search hits are common.
    if (board.elems.size() != 0 && $urandom_range(2) == 0)
      return board.elems[$urandom_range(board.elems.size() - 1)];
    case ($urandom_range(3))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      default: return $urandom();
    endcase
  endfunction

  task automatic random_word();
    logic [OpW-1:0] op;
    logic [PosW-1:0] pos;
    int n;
    n = board.elems.size();
    // Lean toward inserts while short and deletes while long.
    if ($urandom_range(99) < 40)
      op = (n < Capacity / 2) ? OpW'($urandom_range(2)) : OpW'($urandom_range(5, 3));
    else op = OpW'($urandom_range(7));
    if (n != 0 && $urandom_range(3) != 0) pos = PosW'($urandom_range(n - 1));
    else pos = PosW'($urandom());
    send_word(op, pick_value(), pos);
  endtask

  initial begin
    @(posedge rst_ni);
    @(posedge clk_i);
    // Directed: empty-list cases, extremes, fill to full, then drain.
    send_word(ole_pkg::OP_DEL_FRONT, '0, '0);
    send_word(ole_pkg::OP_DEL_BACK, '0, '0);
    send_word(ole_pkg::OP_DEL_AT, '0, '0);
    send_word(ole_pkg::OP_SEARCH, '0, '0);
    send_word(ole_pkg::OP_DUMP, '0, '0);
    send_word(ole_pkg::OP_INS_AFTER, 32'h1234_5678, '0);
    send_word(ole_pkg::OP_INS_FRONT, 32'h8000_0000, '0);
    send_word(ole_pkg::OP_INS_BACK, 32'h7fff_ffff, '0);
    send_word(ole_pkg::OP_INS_AFTER, 32'hffff_ffff, 6'd0);
    send_word(ole_pkg::OP_INS_AFTER, 32'h0, 6'd3);
    send_word(ole_pkg::OP_INS_AFTER, 32'h0, 6'd63);
    send_word(ole_pkg::OP_DEL_AT, '0, 6'd63);
    send_word(ole_pkg::OP_SEARCH, 32'h7fff_ffff, '0);
    send_word(ole_pkg::OP_SEARCH, 32'h5555_aaaa, '0);
    for (int i = 0; i < 13; i++) send_word(ole_pkg::OP_INS_BACK, $urandom(), '0);
    send_word(ole_pkg::OP_INS_FRONT, 32'h1, '0);
    send_word(ole_pkg::OP_INS_AFTER, 32'h2, 6'd0);
    send_word(ole_pkg::OP_DUMP, '0, '0);
    send_word(ole_pkg::OP_DEL_AT, '0, 6'd15);
    send_word(ole_pkg::OP_DEL_AT, '0, 6'd1);
    send_word(ole_pkg::OP_DEL_FRONT, '0, '0);
    send_word(ole_pkg::OP_DEL_BACK, '0, '0);
    drain();

    for (int phase = 0; phase < 3; phase++) begin
      send_idle_pct = (phase == 0) ? 34 : (phase == 1) ? 81 : 0;
      recv_idle_pct = (phase == 0) ? 81 : (phase == 1) ? 34 : 0;
      for (int k = 0; k < 62; k++) begin
        random_word();
        if (k == 31) drain();
      end
    end
    drain();
    repeat (200) @(posedge clk_i);
    if (board.errors == 0 && board.pending.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
